>>> sv/fnvlp_pkg.sv
// Shared types and constants for the FNV-1a linear-probe hash index.
// Command and status codes, FNV constants and the slot entry layout.
// No dependencies.
`timescale 1ns / 1ps

package fnvlp_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned CAP_LG_W = 4;

  // Largest log2 capacity that the slot index can carry
  localparam logic [CAP_LG_W-1:0] CAP_LG_MAX   = 4'd10;
  localparam logic [CAP_LG_W-1:0] CAP_LG_MIN   = 4'd1;
  localparam logic [CAP_LG_W-1:0] CAP_LG_RESET = 4'd10;

  localparam logic [WORD_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [WORD_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic [CMD_W-1:0] CMD_KEY_BYTE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_NEXT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_INSERTED    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FOUND       = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ZERO_OFFSET = 3'd4;

  typedef struct packed {
    logic              used;
    logic [WORD_W-1:0] hash;
    logic [WORD_W-1:0] offset;
  } slot_entry_t;

  // One FNV-1a round: xor the byte in, multiply by the prime modulo 2^32
  function automatic logic [WORD_W-1:0] fnv_round(input logic [WORD_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] x;
    x = h ^ {{(WORD_W-BYTE_W){1'b0}}, b};
    return x * FNV_PRIME;
  endfunction

endpackage

>>> sv/fnv_linear_probe_hash_index_unit.sv
// FNV-1a hash index with a linear-probe slot table in one block RAM.
// Depends on fnvlp_pkg (codes, constants, slot entry type).
// Key byte: taken while idle, busy stays low, no result.
// Insert/lookup: a read state and a check state per slot visited on the single RAM, result
// strobe the cycle after the ending state; zero-offset insert answers the cycle after it is taken.
// Clear, and the sweep after reset: one slot per cycle over the whole table, busy high.
// Reset is synchronous active low; the receiver takes every strobe, no back-pressure.
`timescale 1ns / 1ps

module fnv_linear_probe_hash_index_unit
  import fnvlp_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [BYTE_W-1:0]   in_key_byte,
  input  logic [WORD_W-1:0]   in_entry_offset,
  input  logic                cfg_we,
  input  logic [CAP_LG_W-1:0] cfg_wdata,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_found_offset,
  output logic [SLOT_W-1:0]   out_slot_index
);

  // Slots actually reachable: largest power of two within TABLE_SLOTS, capped by the index
  localparam int unsigned FLOOR_LG = $clog2(TABLE_SLOTS + 1) - 1;
  localparam int unsigned MAX_LG   = (FLOOR_LG > 10) ? 10 : FLOOR_LG;
  localparam int unsigned AW       = MAX_LG;
  localparam int unsigned DEPTH    = 1 << MAX_LG;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_PROBE_RD = 3'd2;
  localparam logic [2:0] S_PROBE_CK = 3'd3;
  localparam logic [2:0] S_INS_RD   = 3'd4;
  localparam logic [2:0] S_INS_CK   = 3'd5;

  localparam logic [CAP_LG_W-1:0] LG_TOP = CAP_LG_W'(MAX_LG);

  logic [2:0]          state_r,     state_nxt;
  logic [CAP_LG_W-1:0] cap_lg_r;
  logic [WORD_W-1:0]   run_hash_r,  run_hash_nxt;
  logic [WORD_W-1:0]   srch_hash_r, srch_hash_nxt;
  logic [AW-1:0]       cursor_r,    cursor_nxt;
  logic [AW:0]         probes_r,    probes_nxt;
  logic                active_r,    active_nxt;
  logic [WORD_W-1:0]   ins_hash_r,  ins_hash_nxt;
  logic [WORD_W-1:0]   ins_off_r,   ins_off_nxt;
  logic [AW-1:0]       ins_slot_r,  ins_slot_nxt;
  logic [AW:0]         ins_cnt_r,   ins_cnt_nxt;
  logic [AW-1:0]       clr_idx_r,   clr_idx_nxt;

  logic                strobe_r,    strobe_nxt;
  logic [STATUS_W-1:0] status_r,    status_nxt;
  logic [WORD_W-1:0]   offset_r,    offset_nxt;
  logic [SLOT_W-1:0]   slot_r,      slot_nxt;

  logic [CAP_LG_W-1:0] lg_eff;
  logic [AW:0]         cap;
  logic [AW-1:0]       mask;
  logic [AW-1:0]       probe_slot;
  logic                accept;

  slot_entry_t         mem [DEPTH];
  slot_entry_t         rd_q;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  slot_entry_t         wr_data;

  // Clamp the capacity setting between CAP_LG_MIN and what the table holds
  always_comb begin
    if (cap_lg_r < CAP_LG_MIN) begin
      lg_eff = CAP_LG_MIN;
    end else if (cap_lg_r > LG_TOP) begin
      lg_eff = LG_TOP;
    end else begin
      lg_eff = cap_lg_r;
    end
  end

  assign cap        = (AW+1)'(1) << lg_eff;
  assign mask       = AW'(cap - (AW+1)'(1));
  assign probe_slot = cursor_r & mask;
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;

  // Single RAM: one write, one registered read per cycle
  assign rd_addr = (state_r == S_PROBE_RD) ? probe_slot : ins_slot_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    run_hash_nxt  = run_hash_r;
    srch_hash_nxt = srch_hash_r;
    cursor_nxt    = cursor_r;
    probes_nxt    = probes_r;
    active_nxt    = active_r;
    ins_hash_nxt  = ins_hash_r;
    ins_off_nxt   = ins_off_r;
    ins_slot_nxt  = ins_slot_r;
    ins_cnt_nxt   = ins_cnt_r;
    clr_idx_nxt   = clr_idx_r;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    offset_nxt    = offset_r;
    slot_nxt      = slot_r;
    wr_en         = 1'b0;
    wr_addr       = ins_slot_r;
    wr_data       = '{used: 1'b1, hash: ins_hash_r, offset: ins_off_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_KEY_BYTE: begin
              run_hash_nxt = fnv_round(run_hash_r, in_key_byte);
            end
            CMD_INSERT: begin
              run_hash_nxt = FNV_BASIS;
              if (in_entry_offset == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = STAT_ZERO_OFFSET;
                offset_nxt = '0;
                slot_nxt   = '0;
              end else begin
                ins_hash_nxt = run_hash_r;
                ins_off_nxt  = in_entry_offset;
                ins_slot_nxt = run_hash_r[AW-1:0] & mask;
                ins_cnt_nxt  = '0;
                state_nxt    = S_INS_RD;
              end
            end
            CMD_LOOKUP: begin
              srch_hash_nxt = run_hash_r;
              run_hash_nxt  = FNV_BASIS;
              cursor_nxt    = run_hash_r[AW-1:0] & mask;
              probes_nxt    = '0;
              active_nxt    = 1'b1;
              state_nxt     = S_PROBE_RD;
            end
            CMD_LOOKUP_NEXT: begin
              state_nxt = S_PROBE_RD;
            end
            CMD_CLEAR: begin
              active_nxt  = 1'b0;
              clr_idx_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: begin
              // unused codes: drop the transaction
            end
          endcase
        end
      end

      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '{used: 1'b0, hash: '0, offset: '0};
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Stop the search when inactive or out of probes, else read the slot
      S_PROBE_RD: begin
        if (!active_r || probes_r >= cap) begin
          active_nxt = 1'b0;
          strobe_nxt = 1'b1;
          status_nxt = STAT_NOT_FOUND;
          offset_nxt = '0;
          slot_nxt   = '0;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_PROBE_CK;
        end
      end

      S_PROBE_CK: begin
        if (!rd_q.used) begin
          active_nxt = 1'b0;
          strobe_nxt = 1'b1;
          status_nxt = STAT_NOT_FOUND;
          offset_nxt = '0;
          slot_nxt   = '0;
          state_nxt  = S_IDLE;
        end else begin
          probes_nxt = probes_r + (AW+1)'(1);
          cursor_nxt = (probe_slot + AW'(1)) & mask;
          if (rd_q.hash == srch_hash_r) begin
            strobe_nxt = 1'b1;
            status_nxt = STAT_FOUND;
            offset_nxt = rd_q.offset;
            slot_nxt   = SLOT_W'(probe_slot);
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_PROBE_RD;
          end
        end
      end

      S_INS_RD: begin
        if (ins_cnt_r >= cap) begin
          strobe_nxt = 1'b1;
          status_nxt = STAT_FULL;
          offset_nxt = '0;
          slot_nxt   = '0;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_INS_CK;
        end
      end

      // Take the first free slot, else advance with wrap
      S_INS_CK: begin
        if (!rd_q.used) begin
          wr_en      = 1'b1;
          strobe_nxt = 1'b1;
          status_nxt = STAT_INSERTED;
          offset_nxt = '0;
          slot_nxt   = SLOT_W'(ins_slot_r);
          state_nxt  = S_IDLE;
        end else begin
          ins_cnt_nxt  = ins_cnt_r + (AW+1)'(1);
          ins_slot_nxt = (ins_slot_r + AW'(1)) & mask;
          state_nxt    = S_INS_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cap_lg_r    <= CAP_LG_RESET;
      run_hash_r  <= FNV_BASIS;
      srch_hash_r <= '0;
      cursor_r    <= '0;
      probes_r    <= '0;
      active_r    <= 1'b0;
      ins_cnt_r   <= '0;
      clr_idx_r   <= '0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cap_lg_r <= cfg_wdata;
      end
      run_hash_r  <= run_hash_nxt;
      srch_hash_r <= srch_hash_nxt;
      cursor_r    <= cursor_nxt;
      probes_r    <= probes_nxt;
      active_r    <= active_nxt;
      ins_cnt_r   <= ins_cnt_nxt;
      clr_idx_r   <= clr_idx_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ins_hash_r <= ins_hash_nxt;
    ins_off_r  <= ins_off_nxt;
    ins_slot_r <= ins_slot_nxt;
    status_r   <= status_nxt;
    offset_r   <= offset_nxt;
    slot_r     <= slot_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_found_offset = offset_r;
  assign out_slot_index   = slot_r;

endmodule
